// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition at one edge that forces another at the following edge.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/iatf_pkg.sv =====
// Package of types, constants and helper functions for the attribute filter.
`timescale 1ns / 1ps

package iatf_pkg;

  // Output slots of one job: two escape sequences of fifteen slots, then the text byte.
  localparam int unsigned ESC_SLOTS  = 15;
  localparam int unsigned JOB_SLOTS  = 2 * ESC_SLOTS + 1;
  localparam int unsigned SLOT_W     = $clog2(JOB_SLOTS);
  localparam int unsigned BYTE_SLOT  = JOB_SLOTS - 1;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [4:0] FL_BOLD = 5'h01;
  localparam logic [4:0] FL_REV  = 5'h02;
  localparam logic [4:0] FL_UND  = 5'h04;
  localparam logic [4:0] FL_FG   = 5'h08;
  localparam logic [4:0] FL_BG   = 5'h10;

  localparam logic [7:0] CH_BOLD    = 8'h02;
  localparam logic [7:0] CH_COLOUR  = 8'h03;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_REV     = 8'h16;
  localparam logic [7:0] CH_UND     = 8'h1F;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_M       = 8'h6D;

  // One unit of work for the serialiser: which slots to send, and their variable contents.
  typedef struct packed {
    logic [JOB_SLOTS-1:0] mask;
    logic [3:0]           fg_digit;
    logic [3:0]           bg_digit;
    logic [7:0]           text;
  } job_t;

  // Palette entry of a colour number, already reduced below ten.
  function automatic logic [3:0] colour_digit(input logic [3:0] idx);
    logic [3:0] d;
    unique case (idx)
      4'd0:    d = 4'd7;
      4'd1:    d = 4'd0;
      4'd2:    d = 4'd4;
      4'd3:    d = 4'd2;
      4'd4:    d = 4'd1;
      4'd5:    d = 4'd3;
      4'd6:    d = 4'd5;
      4'd7:    d = 4'd1;
      4'd8:    d = 4'd3;
      4'd9:    d = 4'd2;
      4'd10:   d = 4'd6;
      4'd11:   d = 4'd6;
      4'd12:   d = 4'd4;
      4'd13:   d = 4'd5;
      4'd14:   d = 4'd0;
      default: d = 4'd7;
    endcase
    return d;
  endfunction

  // Which of the fifteen escape slots are sent for a given set of flags.
  function automatic logic [ESC_SLOTS-1:0] esc_mask(input logic [4:0] f);
    logic [ESC_SLOTS-1:0] m;
    logic b, r, u;
    b = |(f & FL_BOLD);
    r = |(f & FL_REV);
    u = |(f & FL_UND);
    m[0]  = 1'b1;
    m[1]  = 1'b1;
    m[2]  = b;
    m[3]  = b & r;
    m[4]  = r;
    m[5]  = u & (b | r);
    m[6]  = u;
    m[7]  = ~(b | r | u);
    m[8]  = |(f & FL_FG);
    m[9]  = |(f & FL_FG);
    m[10] = |(f & FL_FG);
    m[11] = |(f & FL_BG);
    m[12] = |(f & FL_BG);
    m[13] = |(f & FL_BG);
    m[14] = 1'b1;
    return m;
  endfunction

  // Byte held by one escape slot.
  function automatic logic [7:0] esc_byte(input logic [3:0] k, input logic [3:0] fgd,
                                          input logic [3:0] bgd);
    logic [7:0] v;
    unique case (k)
      4'd0:    v = CH_ESC;
      4'd1:    v = CH_LBRACK;
      4'd2:    v = 8'h31;
      4'd4:    v = 8'h37;
      4'd6:    v = 8'h34;
      4'd7:    v = CH_ZERO;
      4'd9:    v = 8'h33;
      4'd10:   v = CH_ZERO + {4'h0, fgd};
      4'd12:   v = 8'h34;
      4'd13:   v = CH_ZERO + {4'h0, bgd};
      4'd14:   v = CH_M;
      default: v = CH_SEMI;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/iatf_front.sv =====
// Front end: parses the attribute codes and turns each item into a serialiser job.
`timescale 1ns / 1ps

module iatf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             cmd,
  input  logic [7:0]       in_byte,
  input  logic             full,
  output logic             in_stall,
  output logic             push,
  output iatf_pkg::job_t   job
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_CTRL  = 3'd1;
  localparam logic [2:0] PH_FG1   = 3'd2;
  localparam logic [2:0] PH_FG2   = 3'd3;
  localparam logic [2:0] PH_COMMA = 3'd4;
  localparam logic [2:0] PH_BG1   = 3'd5;

  logic [2:0] phase, phase_next;
  logic [4:0] flags, flags_next;
  logic [6:0] fore, fore_next;
  logic [6:0] back, back_next;

  logic       accept;
  logic       is_digit;
  logic [3:0] digit;
  logic [9:0] fore_x10;
  logic [9:0] back_x10;
  logic       esc0_en, esc1_en, text_en, do_plain;
  logic [4:0] esc0_flags, plain_flags;

  assign in_stall = full;
  assign accept   = in_valid & ~full;
  assign is_digit = (in_byte >= iatf_pkg::CH_ZERO) && (in_byte <= iatf_pkg::CH_NINE);
  assign digit    = in_byte[3:0];
  assign fore_x10 = {fore, 3'b000} + {2'b00, fore, 1'b0};
  assign back_x10 = {back, 3'b000} + {2'b00, back, 1'b0};

  always_comb begin
    phase_next  = PH_IDLE;
    flags_next  = flags;
    fore_next   = fore;
    back_next   = back;
    esc0_en     = 1'b0;
    esc0_flags  = flags;
    esc1_en     = 1'b0;
    text_en     = 1'b0;
    do_plain    = 1'b0;
    plain_flags = flags;

    if (cmd) begin
      // End of stream: flush whatever colour code is still open.
      priority if (phase == PH_CTRL) begin
        flags_next = flags & ~(iatf_pkg::FL_FG | iatf_pkg::FL_BG);
        esc0_en    = 1'b1;
      end else if (phase == PH_FG1) begin
        flags_next = flags | iatf_pkg::FL_FG;
        esc0_en    = 1'b1;
      end else if (phase == PH_BG1) begin
        flags_next = flags | iatf_pkg::FL_BG;
        esc0_en    = 1'b1;
      end else begin
        flags_next = flags;
      end
      esc0_flags = flags_next;
    end else begin
      unique case (phase)
        PH_CTRL: begin
          if (is_digit) begin
            fore_next  = {3'b000, digit};
            phase_next = PH_FG1;
          end else begin
            plain_flags = flags & ~(iatf_pkg::FL_FG | iatf_pkg::FL_BG);
            esc0_en     = 1'b1;
            esc0_flags  = plain_flags;
            do_plain    = 1'b1;
          end
        end
        PH_FG1: begin
          esc0_en    = 1'b1;
          esc0_flags = flags | iatf_pkg::FL_FG;
          flags_next = esc0_flags;
          if (is_digit) begin
            fore_next  = fore_x10[6:0] + {3'b000, digit};
            phase_next = PH_FG2;
          end else if (in_byte == iatf_pkg::CH_COMMA) begin
            phase_next = PH_COMMA;
          end else begin
            plain_flags = esc0_flags;
            do_plain    = 1'b1;
          end
        end
        PH_FG2: begin
          if (in_byte == iatf_pkg::CH_COMMA) begin
            phase_next = PH_COMMA;
          end else begin
            do_plain = 1'b1;
          end
        end
        PH_COMMA: begin
          if (is_digit) begin
            back_next  = {3'b000, digit};
            phase_next = PH_BG1;
          end else begin
            do_plain = 1'b1;
          end
        end
        PH_BG1: begin
          esc0_en    = 1'b1;
          esc0_flags = flags | iatf_pkg::FL_BG;
          flags_next = esc0_flags;
          if (is_digit) begin
            back_next = back_x10[6:0] + {3'b000, digit};
          end else begin
            plain_flags = esc0_flags;
            do_plain    = 1'b1;
          end
        end
        default: begin
          do_plain = 1'b1;
        end
      endcase

      // Ordinary byte handling, also reached by a byte that ends a colour code.
      if (do_plain) begin
        flags_next = plain_flags;
        unique case (in_byte)
          iatf_pkg::CH_BOLD: begin
            flags_next = plain_flags ^ iatf_pkg::FL_BOLD;
            esc1_en    = 1'b1;
          end
          iatf_pkg::CH_REV: begin
            flags_next = plain_flags ^ iatf_pkg::FL_REV;
            esc1_en    = 1'b1;
          end
          iatf_pkg::CH_UND: begin
            flags_next = plain_flags ^ iatf_pkg::FL_UND;
            esc1_en    = 1'b1;
          end
          iatf_pkg::CH_COLOUR: begin
            phase_next = PH_CTRL;
          end
          iatf_pkg::CH_NEWLINE: begin
            flags_next = 5'h00;
            esc1_en    = 1'b1;
            text_en    = 1'b1;
          end
          default: begin
            text_en = 1'b1;
          end
        endcase
      end
    end
  end

  // Both escapes of one item see the same colour numbers, so one digit pair serves.
  always_comb begin
    job.mask = {text_en,
                esc1_en ? iatf_pkg::esc_mask(flags_next) : {iatf_pkg::ESC_SLOTS{1'b0}},
                esc0_en ? iatf_pkg::esc_mask(esc0_flags) : {iatf_pkg::ESC_SLOTS{1'b0}}};
    job.fg_digit = iatf_pkg::colour_digit(fore_next[3:0]);
    job.bg_digit = iatf_pkg::colour_digit(back_next[3:0]);
    job.text     = in_byte;
  end

  // Items that produce no output, such as the first digit of a colour number, never reach the queue.
  assign push = accept & (|job.mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      flags <= 5'h00;
      fore  <= 7'h00;
      back  <= 7'h00;
    end else if (accept) begin
      phase <= phase_next;
      flags <= flags_next;
      fore  <= fore_next;
      back  <= back_next;
    end
  end

endmodule

// ===== rtl/iatf_queue.sv =====
// Short job queue that decouples the parser from the serialiser.
`timescale 1ns / 1ps

module iatf_queue #(
  parameter int unsigned DEPTH = iatf_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  iatf_pkg::job_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output iatf_pkg::job_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  iatf_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/iatf_back.sv =====
// Back end: serialises one job into output bytes, one byte a cycle while the output is not stalled.
`timescale 1ns / 1ps

module iatf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  iatf_pkg::job_t head,
  output logic           pop,
  output logic           busy,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           last
);

  logic [iatf_pkg::JOB_SLOTS-1:0] cur_mask;
  logic [3:0]                     cur_fgd, cur_bgd;
  logic [7:0]                     cur_text;

  logic                           advance, emit;
  logic [iatf_pkg::JOB_SLOTS-1:0] src_mask, rest_mask;
  logic [3:0]                     src_fgd, src_bgd;
  logic [7:0]                     src_text;
  logic [iatf_pkg::SLOT_W-1:0]    slot;
  logic [iatf_pkg::SLOT_W-1:0]    esc_slot;
  logic [7:0]                     slot_byte;

  assign busy    = |cur_mask;
  assign advance = ~out_valid | ~out_stall;
  assign emit    = advance & (busy | head_valid);
  assign pop     = advance & ~busy & head_valid;

  // A job in progress has priority; otherwise the queue head is started directly.
  always_comb begin
    if (busy) begin
      src_mask = cur_mask;
      src_fgd  = cur_fgd;
      src_bgd  = cur_bgd;
      src_text = cur_text;
    end else begin
      src_mask = head.mask;
      src_fgd  = head.fg_digit;
      src_bgd  = head.bg_digit;
      src_text = head.text;
    end
  end

  // Lowest pending slot goes out next.
  always_comb begin
    slot = '0;
    for (int i = iatf_pkg::JOB_SLOTS - 1; i >= 0; i--) begin
      if (src_mask[i]) begin
        slot = iatf_pkg::SLOT_W'(i);
      end
    end
  end

  assign rest_mask = src_mask & (src_mask - 1'b1);
  assign esc_slot  = (slot >= iatf_pkg::SLOT_W'(iatf_pkg::ESC_SLOTS))
                   ? slot - iatf_pkg::SLOT_W'(iatf_pkg::ESC_SLOTS) : slot;

  always_comb begin
    if (slot == iatf_pkg::SLOT_W'(iatf_pkg::BYTE_SLOT)) begin
      slot_byte = src_text;
    end else begin
      slot_byte = iatf_pkg::esc_byte(esc_slot[3:0], src_fgd, src_bgd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mask  <= '0;
      out_valid <= 1'b0;
    end else if (emit) begin
      cur_mask  <= rest_mask;
      out_valid <= 1'b1;
    end else if (advance) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_fgd  <= head.fg_digit;
      cur_bgd  <= head.bg_digit;
      cur_text <= head.text;
    end
    if (emit) begin
      out_byte <= slot_byte;
      last     <= (rest_mask == '0);
    end
  end

endmodule

// ===== rtl/irc_attr_to_ansi_filter_core.sv =====
// An item's job is queued, then its first byte is registered at the output.
// Throughput: one output byte per cycle from the serialiser while not stalled.
// A plain text byte gives one byte, an attribute change 4 to 14 bytes per escape,
// at most 28 for one item. Input continues while the two-entry job queue has room.
// Reset clears the parser state, flags, colour numbers, the job queue and the output.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module irc_attr_to_ansi_filter_core #(
  parameter int unsigned QUEUE_DEPTH = iatf_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last
);

  logic           push, pop, full, head_valid, busy;
  logic           back_drained;
  iatf_pkg::job_t push_job, head_job;

  iatf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_byte  (in_byte),
    .full     (full),
    .in_stall (in_stall),
    .push     (push),
    .job      (push_job)
  );

  iatf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_job),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head_job)
  );

  iatf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head_job),
    .pop        (pop),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .last       (last)
  );

  assign back_drained = !head_valid && !busy && (!out_valid || !out_stall);

  // A partly sent job always has its previous byte waiting in the output register.
  `ASSERT_ALWAYS(a_busy_has_output, !busy || out_valid, "serialiser busy without output")

  // With nothing queued or in progress, a drained output register stays empty.
  `ASSERT_NEXT(a_idle_stays_empty, back_drained, !out_valid, "output from an empty back end")

  // A stalled input means the queue holds work for the serialiser.
  `ASSERT_ALWAYS(a_stall_has_work, !in_stall || head_valid, "input stalled with an empty queue")

endmodule
